/* sv/tcls_pkg.sv */
// Package for the Thumb call and literal scanner: store sizing, decode masks,
// decode helper functions and the control structs between top level and store.
// No dependencies.
package tcls_pkg;

  // Literal store sizing
  localparam int unsigned LitSlots = 8;
  localparam int unsigned CountW   = $clog2(LitSlots + 1);
  localparam int unsigned IdxW     = (LitSlots > 1) ? $clog2(LitSlots) : 1;

  // Decode masks and match values (mask / value pairs)
  localparam logic [15:0] MaskTop5   = 16'hF800;
  localparam logic [15:0] ValBlHi    = 16'hF000;
  localparam logic [15:0] MaskBlLo   = 16'hD000;
  localparam logic [15:0] ValLdrLit  = 16'h4800;
  localparam logic [15:0] MaskDpReg  = 16'hEE00;
  localparam logic [15:0] ValDpReg   = 16'hEA00;
  localparam logic [15:0] MaskTop7   = 16'hFE00;
  localparam logic [15:0] ValLdStW   = 16'hF800;
  localparam logic [15:0] MaskLdStM  = 16'hFE40;
  localparam logic [15:0] ValLdStDx  = 16'hE840;
  localparam logic [15:0] ValLdStM   = 16'hE800;
  localparam logic [15:0] MaskTop8   = 16'hFF00;
  localparam logic [15:0] ValWide7F  = 16'h7F00;

  // Commands into the literal store
  typedef struct packed {
    logic        clear;   // start of a new function
    logic        take;    // remove the minimum entries equal to probe
    logic        insert;  // add value in sorted position
    logic [31:0] probe;   // offset of the current halfword
    logic [31:0] value;   // literal offset to insert
  } lit_cmd_t;

  // Status back from the literal store
  typedef struct packed {
    logic hit;   // smallest pending offset equals probe
    logic full;  // no free slot
  } lit_status_t;

  // First halfword of a 32-bit instruction
  function automatic logic is_wide(input logic [15:0] h);
    return ((h & MaskTop5) == ValBlHi) || ((h & MaskDpReg) == ValDpReg) ||
           ((h & MaskTop7) == ValLdStW) || ((h & MaskLdStM) == ValLdStDx) ||
           ((h & MaskLdStM) == ValLdStM) || ((h & MaskTop8) == ValWide7F);
  endfunction

  // BL encoding across both halfwords
  function automatic logic is_bl(input logic [15:0] h1, input logic [15:0] h2);
    return ((h1 & MaskTop5) == ValBlHi) && ((h2 & MaskBlLo) == MaskBlLo);
  endfunction

  // Sign-extended BL displacement
  function automatic logic [31:0] bl_imm(input logic [15:0] h1, input logic [15:0] h2);
    logic s;
    s = h1[10];
    return {{8{s}}, ~(h2[13] ^ s), ~(h2[11] ^ s), h1[9:0], h2[10:0], 1'b0};
  endfunction

  // PC-relative literal load (LDR Rt,[PC,#imm])
  function automatic logic is_lit_load(input logic [15:0] h);
    return (h & MaskTop5) == ValLdrLit;
  endfunction

  // Section-relative literal offset of a PC-relative load
  function automatic logic [31:0] lit_offset(input logic [31:0] off,
                                             input logic [15:0] h);
    logic [31:0] pc;
    pc = off + 32'd4;
    return {pc[31:2], 2'b00} + {22'd0, h[7:0], 2'b00};
  endfunction

endpackage

/* sv/tcls_lit_store.sv */
// Sorted store of pending literal offsets, smallest first, for the scanner.
// Depends on tcls_pkg for sizing and the command and status structs.
module tcls_lit_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcls_pkg::lit_cmd_t    cmd_i,
  output tcls_pkg::lit_status_t status_o
);
  import tcls_pkg::*;

  logic [31:0]        slot_q [LitSlots];
  logic [31:0]        slot_d [LitSlots];
  logic [CountW-1:0]  count_q, count_d, count_eff;
  logic [CountW-1:0]  n_take, ins_pos;
  logic [LitSlots-1:0] valid, eq, le;

  // Compare every live entry against the probe and the new value
  always_comb begin
    count_eff = cmd_i.clear ? '0 : count_q;
    for (int k = 0; k < LitSlots; k++) begin
      valid[k] = CountW'(k) < count_eff;
      eq[k]    = valid[k] && (slot_q[k] == cmd_i.probe);
      le[k]    = valid[k] && (slot_q[k] <= cmd_i.value);
    end
    n_take          = CountW'($countones(eq));
    ins_pos         = CountW'($countones(le));
    status_o.hit    = eq[0];
    status_o.full   = count_eff >= CountW'(LitSlots);
  end

  // Shift out the taken minimum or open a gap for the insert
  always_comb begin
    logic [CountW:0] src;
    slot_d  = slot_q;
    count_d = count_eff;
    src     = '0;
    if (cmd_i.take && status_o.hit) begin
      for (int k = 0; k < LitSlots; k++) begin
        src = (CountW + 1)'(k) + {1'b0, n_take};
        if (src < (CountW + 1)'(LitSlots)) begin
          slot_d[k] = slot_q[src[IdxW-1:0]];
        end
      end
      count_d = count_eff - n_take;
    end else if (cmd_i.insert && !status_o.full) begin
      for (int k = 0; k < LitSlots; k++) begin
        if (CountW'(k) == ins_pos) begin
          slot_d[k] = cmd_i.value;
        end else if (CountW'(k) > ins_pos) begin
          slot_d[k] = slot_q[IdxW'(k - 1)];
        end
      end
      count_d = count_eff + CountW'(1);
    end
  end

  // Hold entries; no reset, the count says which are live
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

/* sv/thumb_call_and_literal_scanner.sv */
// Thumb call and literal scanner, top level.
// Depends on tcls_pkg and tcls_lit_store.
//
// Takes one code halfword per cycle and answers each BL with one word in the
// cycle after, held in an output register; the input stays ready while that
// register is empty or being drained, so a full cycle-per-halfword stream runs
// with no gaps. Each halfword is decoded, checked against the smallest pending
// literal offset and the literal store updated in the same cycle it is taken.
// The store has eight slots and needs no clearing pass after reset. Write
// section_base_address only while the block is idle.
module thumb_call_and_literal_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  // halfword input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_halfword_i,
  input  logic [31:0] byte_offset_i,
  input  logic        first_of_function_i,
  input  logic        last_of_function_i,
  // call result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] call_address_o,
  output logic [31:0] call_target_o,
  output logic [31:0] r0_literal_address_o,
  output logic        r0_seen_o,
  output logic        literal_overflow_o
);
  import tcls_pkg::*;

  logic [31:0] base_q;
  logic [15:0] held_q, held_d;
  logic        held_valid_q, held_valid_d;
  logic        skip_q, skip_d;
  logic [31:0] r0_lit_q, r0_lit_d;
  logic        r0_seen_q, r0_seen_d;
  logic        ovf_q, ovf_d;
  logic        out_valid_q;
  logic [31:0] call_addr_q, call_tgt_q, out_r0_q;
  logic        out_seen_q, out_ovf_q;

  logic        accept, emit;
  logic [31:0] lit_off;
  lit_cmd_t    st_cmd;
  lit_status_t st_status;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign lit_off     = lit_offset(byte_offset_i, code_halfword_i);

  // Decode one halfword against the current state
  always_comb begin
    logic eff_held, eff_skip;
    eff_held     = held_valid_q && !first_of_function_i;
    eff_skip     = skip_q && !first_of_function_i;
    held_d       = held_q;
    held_valid_d = eff_held;
    skip_d       = eff_skip;
    r0_lit_d     = first_of_function_i ? '0 : r0_lit_q;
    r0_seen_d    = r0_seen_q && !first_of_function_i;
    ovf_d        = ovf_q;
    emit         = 1'b0;
    st_cmd.clear  = accept && first_of_function_i;
    st_cmd.take   = 1'b0;
    st_cmd.insert = 1'b0;
    st_cmd.probe  = byte_offset_i;
    st_cmd.value  = lit_off;
    if (eff_skip) begin
      skip_d = 1'b0;
    end else if (eff_held) begin
      held_valid_d = 1'b0;
      emit         = is_bl(held_q, code_halfword_i);
    end else if (st_status.hit) begin
      st_cmd.take = accept;
      skip_d      = 1'b1;
    end else if (!last_of_function_i && is_wide(code_halfword_i)) begin
      held_d       = code_halfword_i;
      held_valid_d = 1'b1;
    end else if (is_lit_load(code_halfword_i)) begin
      st_cmd.insert = accept;
      if (st_status.full) begin
        ovf_d = 1'b1;
      end
      if (code_halfword_i[10:8] == 3'd0) begin
        r0_lit_d  = lit_off + base_q;
        r0_seen_d = 1'b1;
      end
    end
  end

  tcls_lit_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (st_cmd),
    .status_o (st_status)
  );

  // Take configuration writes; advance scan state on each accepted halfword
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      held_valid_q <= 1'b0;
      skip_q       <= 1'b0;
      r0_lit_q     <= '0;
      r0_seen_q    <= 1'b0;
      ovf_q        <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_data_i;
      end
      if (accept) begin
        held_valid_q <= held_valid_d;
        skip_q       <= skip_d;
        r0_lit_q     <= r0_lit_d;
        r0_seen_q    <= r0_seen_d;
        ovf_q        <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

  // Hold the result word until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      call_addr_q <= base_q + byte_offset_i - 32'd2;
      call_tgt_q  <= byte_offset_i + 32'd2 + bl_imm(held_q, code_halfword_i) + base_q;
      out_r0_q    <= r0_lit_q;
      out_seen_q  <= r0_seen_q;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign call_address_o       = call_addr_q;
  assign call_target_o        = call_tgt_q;
  assign r0_literal_address_o = out_r0_q;
  assign r0_seen_o            = out_seen_q;
  assign literal_overflow_o   = out_ovf_q;

  // A stalled result word must block new input
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("result word overwritten while stalled");

  // A pending skip and a held first halfword never coexist
  a_skip_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(skip_q && held_valid_q))
    else $error("skip and held halfword both pending");

  // Overflow only rises after an insert into a full store
  a_ovf_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(st_cmd.insert && st_status.full))
    else $error("overflow flag set without a dropped literal");

endmodule

/* tb/sv/tb_thumb_call_and_literal_scanner.sv */
// Self-checking testbench for thumb_call_and_literal_scanner: directed table, then random
// function streams, each call word checked against a cycle-free model of the scanner.
// Depends on the scanner RTL only (tcls_pkg and the top level with its literal store).
`timescale 1ns / 1ps

module tb_thumb_call_and_literal_scanner;

  // Decode masks for the scanner model
  localparam logic [15:0] CallHiMask = 16'hF800;
  localparam logic [15:0] CallHiVal  = 16'hF000;
  localparam logic [15:0] CallLoMask = 16'hD000;
  localparam logic [15:0] LdrLitMask = 16'hF800;
  localparam logic [15:0] LdrLitVal  = 16'h4800;
  localparam logic [15:0] DpMask     = 16'hEE00;
  localparam logic [15:0] DpVal      = 16'hEA00;
  localparam logic [15:0] LsMask     = 16'hFE00;
  localparam logic [15:0] LsVal      = 16'hF800;
  localparam logic [15:0] LdmMask    = 16'hFE40;
  localparam logic [15:0] DualVal    = 16'hE840;
  localparam logic [15:0] MultVal    = 16'hE800;
  localparam logic [15:0] SevenMask  = 16'hFF00;
  localparam logic [15:0] SevenVal   = 16'h7F00;
  localparam int unsigned LitCapacity = 8;
  localparam int          ReportLimit = 10;
  localparam int          PhaseItems  = 280;

  typedef struct packed {
    logic [31:0] call_address;
    logic [31:0] call_target;
    logic [31:0] r0_literal_address;
    logic        r0_seen;
    logic        literal_overflow;
  } call_word_t;

  typedef struct packed {
    logic [15:0] hw;
    logic [31:0] off;
    logic        first;
    logic        last;
    logic        typed;
    call_word_t  word;
  } dir_row_t;

  typedef enum logic [2:0] {
    KindCall, KindR0Load, KindLitLoad, KindWide, KindBadCall, KindShort
  } insn_kind_t;

  typedef enum logic [2:0] {
    FormDataProc, FormLoadStore, FormDual, FormMultiple, FormSeven
  } wide_form_t;

  typedef enum logic [1:0] {RxOpen, RxPeriodic, RxRandom} rx_mode_t;

  // Directed stimulus; typed words only where the result is obvious
  localparam dir_row_t DirRows [0:24] = '{
    // call at the very start, base zero, no literals yet
    '{16'hF000, 32'd0, 1'b1, 1'b0, 1'b0, '0},
    '{16'hF800, 32'd2, 1'b0, 1'b0, 1'b1, '{32'd0, 32'd4, 32'd0, 1'b0, 1'b0}},
    // r0 literal at 12, r2 literal at 24
    '{16'h4801, 32'd4, 1'b0, 1'b0, 1'b0, '0},
    '{16'h4A04, 32'd6, 1'b0, 1'b0, 1'b0, '0},
    // wide non-call pair: no literal check on its partner
    '{16'hE840, 32'd8, 1'b0, 1'b0, 1'b0, '0},
    '{16'hFFFF, 32'd10, 1'b0, 1'b0, 1'b0, '0},
    // literal hit: this and the next halfword are data
    '{16'h0000, 32'd12, 1'b0, 1'b0, 1'b0, '0},
    '{16'hF000, 32'd14, 1'b0, 1'b0, 1'b0, '0},
    // backward call with all displacement bits set
    '{16'hF7FF, 32'd16, 1'b0, 1'b0, 1'b0, '0},
    '{16'hFFFF, 32'd18, 1'b0, 1'b0, 1'b1, '{32'd16, 32'd18, 32'd12, 1'b1, 1'b0}},
    // call prefix with a partner that is not a call suffix
    '{16'hF000, 32'd20, 1'b0, 1'b0, 1'b0, '0},
    '{16'hC000, 32'd22, 1'b0, 1'b0, 1'b0, '0},
    // literal hit on the last halfword leaves a skip pending
    '{16'h7F00, 32'd24, 1'b0, 1'b1, 1'b0, '0},
    // new function near the top of the space: fill the store, wrap offsets
    '{16'h4800, 32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, '0},
    '{16'h4FFF, 32'hFFFF_FFF2, 1'b0, 1'b0, 1'b0, '0},
    '{16'h49AA, 32'hFFFF_FFF4, 1'b0, 1'b0, 1'b0, '0},
    '{16'h4A01, 32'hFFFF_FFF6, 1'b0, 1'b0, 1'b0, '0},
    '{16'h4B10, 32'hFFFF_FFF8, 1'b0, 1'b0, 1'b0, '0},
    '{16'h4C20, 32'hFFFF_FFFA, 1'b0, 1'b0, 1'b0, '0},
    '{16'h4D7F, 32'hFFFF_FFFC, 1'b0, 1'b0, 1'b0, '0},
    '{16'h4880, 32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0, '0},
    // ninth literal is dropped, r0 address still moves
    '{16'h4805, 32'd0, 1'b0, 1'b0, 1'b0, '0},
    '{16'hF000, 32'd2, 1'b0, 1'b0, 1'b0, '0},
    '{16'hD000, 32'd4, 1'b0, 1'b0, 1'b0, '0},
    // wide prefix as last halfword counts as 16-bit
    '{16'hF800, 32'd6, 1'b0, 1'b1, 1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] code_halfword_i = '0;
  logic [31:0] byte_offset_i = '0;
  logic        first_of_function_i = 1'b0;
  logic        last_of_function_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] call_address_o;
  logic [31:0] call_target_o;
  logic [31:0] r0_literal_address_o;
  logic        r0_seen_o;
  logic        literal_overflow_o;

  thumb_call_and_literal_scanner dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .code_halfword_i     (code_halfword_i),
    .byte_offset_i       (byte_offset_i),
    .first_of_function_i (first_of_function_i),
    .last_of_function_i  (last_of_function_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .call_address_o      (call_address_o),
    .call_target_o       (call_target_o),
    .r0_literal_address_o(r0_literal_address_o),
    .r0_seen_o           (r0_seen_o),
    .literal_overflow_o  (literal_overflow_o)
  );

  // Scanner model state
  logic [31:0] base_addr = '0;
  logic [15:0] held_hw = '0;
  logic        held_ok = 1'b0;
  logic        skip_pending = 1'b0;
  logic [31:0] lit_q[$];
  logic [31:0] r0_lit_addr = '0;
  logic        r0_hit = 1'b0;
  logic        lit_dropped = 1'b0;

  call_word_t  call_q[$];
  call_word_t  got_word;
  call_word_t  want_word;
  int          errors = 0;
  int          burst_left = 0;
  int          sent_items = 0;
  rx_mode_t    rx_mode = RxOpen;
  int          rx_span = 0;
  int          rx_count = 0;
  int          rx_period = 2;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Advance the scanner model by one halfword
  task automatic scan_halfword(input logic [15:0] hw, input logic [31:0] off,
                               input logic first, input logic last,
                               output logic made, output call_word_t cw);
    logic [15:0] h1;
    logic        s;
    logic [31:0] disp;
    logic [31:0] lit;
    int          n;
    made = 1'b0;
    cw = '0;
    if (first) begin
      lit_q.delete();
      r0_lit_addr = '0;
      r0_hit = 1'b0;
      held_ok = 1'b0;
      held_hw = '0;
      skip_pending = 1'b0;
    end
    if (skip_pending) begin
      skip_pending = 1'b0;
      return;
    end
    // second half of a wide instruction
    if (held_ok) begin
      h1 = held_hw;
      held_ok = 1'b0;
      if ((h1 & CallHiMask) == CallHiVal && (hw & CallLoMask) == CallLoMask) begin
        s = h1[10];
        disp = (s ? 32'hFF00_0000 : 32'h0)
             | ({31'd0, ~(hw[13] ^ s)} << 23) | ({31'd0, ~(hw[11] ^ s)} << 22)
             | (32'(h1[9:0]) << 12) | (32'(hw[10:0]) << 1);
        made = 1'b1;
        cw.call_address = base_addr + off - 32'd2;
        cw.call_target = off + 32'd2 + disp + base_addr;
        cw.r0_literal_address = r0_lit_addr;
        cw.r0_seen = r0_hit;
        cw.literal_overflow = lit_dropped;
      end
      return;
    end
    // drop the smallest pending literal and its duplicates, skip four bytes
    if (lit_q.size() > 0 && lit_q[0] == off) begin
      while (lit_q.size() > 0 && lit_q[0] == off) lit_q.delete(0);
      skip_pending = 1'b1;
      return;
    end
    if (!last && (((hw & CallHiMask) == CallHiVal) || ((hw & DpMask) == DpVal) ||
                  ((hw & LsMask) == LsVal) || ((hw & LdmMask) == DualVal) ||
                  ((hw & LdmMask) == MultVal) || ((hw & SevenMask) == SevenVal))) begin
      held_hw = hw;
      held_ok = 1'b1;
      return;
    end
    // PC-relative literal load: record offset in sorted order, or mark a drop when full
    if ((hw & LdrLitMask) == LdrLitVal) begin
      lit = ((off + 32'd4) & ~32'd3) + (32'(hw[7:0]) << 2);
      if (lit_q.size() >= LitCapacity) begin
        lit_dropped = 1'b1;
      end else begin
        n = 0;
        while (n < lit_q.size() && lit_q[n] <= lit) n++;
        lit_q.insert(n, lit);
      end
      if (hw[10:8] == 3'd0) begin
        r0_lit_addr = lit + base_addr;
        r0_hit = 1'b1;
      end
    end
  endtask

  // Send one halfword word in bursts; record what it should cause
  task automatic send_halfword(input logic [15:0] hw, input logic [31:0] off,
                               input logic first, input logic last,
                               input logic typed, input call_word_t typed_word);
    int         gap;
    logic       made;
    call_word_t cw;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    code_halfword_i <= hw;
    byte_offset_i <= off;
    first_of_function_i <= first;
    last_of_function_i <= last;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    burst_left--;
    sent_items++;
    scan_halfword(hw, off, first, last, made, cw);
    if (typed) call_q.insert(call_q.size(), typed_word);
    else if (made) call_q.insert(call_q.size(), cw);
  endtask

  // Drain, let the block settle, then write the base register
  task automatic write_base(input logic [31:0] value);
    in_valid_i <= 1'b0;
    while (call_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    base_addr = value;
    burst_left = 0;
  endtask

  // One well-formed function with random content
  task automatic send_function();
    logic [15:0] body[$];
    logic [31:0] start;
    logic [15:0] h2;
    int          len;
    int          roll;
    insn_kind_t  kind;
    wide_form_t  form;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    start = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFC0 + 32'(2 * $urandom_range(0, 31))
                                        : $urandom & 32'hFFFF_FFFE;
    while (body.size() < len) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) kind = KindCall;
      else if (roll < 40) kind = KindR0Load;
      else if (roll < 55) kind = KindLitLoad;
      else if (roll < 70) kind = KindWide;
      else if (roll < 75) kind = KindBadCall;
      else kind = KindShort;
      case (kind)
        KindCall: begin
          body.insert(body.size(), CallHiVal | 16'($urandom & 32'h07FF));
          body.insert(body.size(), CallLoMask | 16'($urandom & 32'h2FFF));
        end
        KindR0Load, KindLitLoad: begin
          h2 = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255))
                                          : 16'($urandom_range(0, 7));
          if (kind == KindLitLoad) h2[10:8] = 3'($urandom_range(1, 7));
          body.insert(body.size(), LdrLitVal | h2);
        end
        KindWide: begin
          form = wide_form_t'($urandom_range(0, 4));
          case (form)
            FormDataProc:  body.insert(body.size(), DpVal | (16'($urandom) & ~DpMask));
            FormLoadStore: body.insert(body.size(), LsVal | (16'($urandom) & ~LsMask));
            FormDual:      body.insert(body.size(), DualVal | (16'($urandom) & ~LdmMask));
            FormMultiple:  body.insert(body.size(), MultVal | (16'($urandom) & ~LdmMask));
            default:       body.insert(body.size(), SevenVal | (16'($urandom) & ~SevenMask));
          endcase
          body.insert(body.size(), 16'($urandom));
        end
        KindBadCall: begin
          h2 = 16'($urandom);
          if ((h2 & CallLoMask) == CallLoMask) h2[12] = 1'b0;
          body.insert(body.size(), CallHiVal | 16'($urandom & 32'h07FF));
          body.insert(body.size(), h2);
        end
        default: body.insert(body.size(), 16'($urandom));
      endcase
    end
    // cut to length; a wide prefix may end up last
    while (body.size() > len) void'(body.pop_back());
    for (int i = 0; i < len; i++) begin
      send_halfword(body[i], start + 32'(2 * i), i == 0, i == len - 1, 1'b0, '0);
    end
  endtask

  // Receiver: stall on a changing pattern
  always @(posedge clk_i) begin
    if (rx_count >= rx_span) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_span = $urandom_range(20, 200);
      rx_period = $urandom_range(2, 6);
      rx_count = 0;
    end
    rx_count++;
    case (rx_mode)
      RxOpen:     out_ready_i <= 1'b1;
      RxPeriodic: out_ready_i <= (rx_count % rx_period) == 0;
      default:    out_ready_i <= 1'($urandom_range(0, 1));
    endcase
  end

  // Check each call word on the falling edge of the cycle in which it is taken
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_word = '{call_address_o, call_target_o, r0_literal_address_o,
                   r0_seen_o, literal_overflow_o};
      if (call_q.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("unexpected call word: addr=%h target=%h r0=%h seen=%b ovf=%b",
                   got_word.call_address, got_word.call_target,
                   got_word.r0_literal_address, got_word.r0_seen,
                   got_word.literal_overflow);
      end else begin
        want_word = call_q.pop_front();
        if (got_word.call_address !== want_word.call_address ||
            got_word.call_target !== want_word.call_target ||
            got_word.r0_literal_address !== want_word.r0_literal_address ||
            got_word.r0_seen !== want_word.r0_seen ||
            got_word.literal_overflow !== want_word.literal_overflow) begin
          errors++;
          if (errors <= ReportLimit)
            $display({"call word mismatch: expected addr=%h target=%h r0=%h seen=%b ",
                      "ovf=%b, got addr=%h target=%h r0=%h seen=%b ovf=%b"},
                     want_word.call_address, want_word.call_target,
                     want_word.r0_literal_address, want_word.r0_seen,
                     want_word.literal_overflow, got_word.call_address,
                     got_word.call_target, got_word.r0_literal_address,
                     got_word.r0_seen, got_word.literal_overflow);
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [31:0] bases [5];
    bases = '{32'hFFFF_FFFF, $urandom, 32'h0800_0000, 32'h8000_0000, $urandom};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_base(32'h0);
    foreach (DirRows[i]) begin
      send_halfword(DirRows[i].hw, DirRows[i].off, DirRows[i].first, DirRows[i].last,
                    DirRows[i].typed, DirRows[i].word);
    end
    // random phases, one base setting each
    foreach (bases[p]) begin
      write_base(bases[p]);
      sent_items = 0;
      while (sent_items < PhaseItems) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4))
            send_halfword(16'($urandom), $urandom, 1'($urandom), 1'($urandom), 1'b0, '0);
        end else begin
          send_function();
        end
      end
    end
    in_valid_i <= 1'b0;
    while (call_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hold a hard limit on the run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
sv/tcls_pkg.sv
sv/tcls_lit_store.sv
sv/thumb_call_and_literal_scanner.sv
tb/sv/tb_thumb_call_and_literal_scanner.sv
